// File: hw/rtl/sgm_pkg.sv
// Shared types and constants for the Sobel gradient magnitude/direction pipeline.
// No dependencies; imported by every module of the block.
package sgm_pkg;

    localparam int PIX_W  = 8;
    localparam int GRAD_W = 11;   // signed gv/gh, range +/-1020
    localparam int ABS_W  = 10;
    localparam int SQ_W   = 20;
    localparam int SUM_W  = 21;
    localparam int VAL_W  = 16;
    localparam int REM_W  = 10;
    localparam int ROOT_W = 8;
    localparam int SQRT_STAGES = 4;
    localparam int SQRT_STEPS  = 2;   // result bits per sqrt stage

    // tan(pi/8) and tan(3pi/8) in Q16
    localparam logic [14:0] TAN_LOW_Q16  = 15'd27146;
    localparam logic [17:0] TAN_HIGH_Q16 = 18'd158218;

    localparam logic [1:0] DIR_HORIZ = 2'd0;
    localparam logic [1:0] DIR_VERT  = 2'd1;
    localparam logic [1:0] DIR_PLUS  = 2'd2;
    localparam logic [1:0] DIR_MINUS = 2'd3;

    localparam logic [ROOT_W-1:0] MAG_SAT = '1;

    typedef struct packed {
        logic                     vld;
        logic signed [GRAD_W-1:0] gv;
        logic signed [GRAD_W-1:0] gh;
    } t_sum;

    typedef struct packed {
        logic              vld;
        logic              sat;
        logic [1:0]        dir;
        logic [VAL_W-1:0]  val;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_root;

    typedef struct packed {
        logic              vld;
        logic [ROOT_W-1:0] mag;
        logic [1:0]        dir;
    } t_res;

endpackage

// File: hw/rtl/sgm_window.sv
// Column window: keeps left/center columns, handles row marks, forms Sobel sums.
// Two result lanes: lane A (interior column) and lane B (row flush). Uses sgm_pkg.
module sgm_window (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [2:0][sgm_pkg::PIX_W-1:0] i_col,
    input  logic                        i_first,
    input  logic                        i_final,
    output sgm_pkg::t_sum               o_sum_a,
    output sgm_pkg::t_sum               o_sum_b
);
    import sgm_pkg::*;

    logic [2:0][PIX_W-1:0] r_left, r_center;
    logic [1:0]            r_seen;
    logic [2:0][PIX_W-1:0] n_left, n_center, mid_left;
    logic [1:0]            n_seen;
    logic                  restart;
    t_sum                  r_a, r_b, n_a, n_b;

    function automatic t_sum sobel(input logic [2:0][PIX_W-1:0] l,
                                   input logic [2:0][PIX_W-1:0] c,
                                   input logic [2:0][PIX_W-1:0] r);
        logic [ABS_W-1:0] vp, vn, hp, hn;
        t_sum s;
        vp = ABS_W'(l[2]) + {1'b0, c[2], 1'b0} + ABS_W'(r[2]);
        vn = ABS_W'(l[0]) + {1'b0, c[0], 1'b0} + ABS_W'(r[0]);
        hp = ABS_W'(r[0]) + {1'b0, r[1], 1'b0} + ABS_W'(r[2]);
        hn = ABS_W'(l[0]) + {1'b0, l[1], 1'b0} + ABS_W'(l[2]);
        s.vld = 1'b0;
        s.gv  = signed'({1'b0, vp}) - signed'({1'b0, vn});
        s.gh  = signed'({1'b0, hp}) - signed'({1'b0, hn});
        return s;
    endfunction

    always_comb begin
        restart  = i_first || (r_seen == 2'd0);
        mid_left = restart ? '0 : r_center;
        n_a      = sobel(r_left, r_center, i_col);
        n_a.vld  = i_vld && !restart;
        n_b      = sobel(mid_left, i_col, '0);
        n_b.vld  = i_vld && i_final;
        if (i_final) begin
            n_left   = '0;
            n_center = '0;
            n_seen   = 2'd0;
        end else begin
            n_left   = mid_left;
            n_center = i_col;
            n_seen   = restart ? 2'd1 : 2'd2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_center <= '0;
            r_seen   <= 2'd0;
            r_a.vld  <= 1'b0;
            r_b.vld  <= 1'b0;
        end else if (i_en) begin
            r_a <= n_a;
            r_b <= n_b;
            if (i_vld) begin
                r_left   <= n_left;
                r_center <= n_center;
                r_seen   <= n_seen;
            end
        end
    end

    assign o_sum_a = r_a;
    assign o_sum_b = r_b;

endmodule

// File: hw/rtl/sgm_grad.sv
// Gradient lane: squares, Q16 sector bounds, direction code, sqrt operand setup.
// Two register stages. Uses sgm_pkg.
module sgm_grad (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  sgm_pkg::t_sum  i_sum,
    output sgm_pkg::t_root o_root
);
    import sgm_pkg::*;

    logic [ABS_W-1:0] av, ah;
    logic             r_vld;
    logic             r_same_sign;
    logic [ABS_W-1:0] r_ah;
    logic [SQ_W-1:0]  r_sqv, r_sqh;
    logic [24:0]      r_plo;
    logic [27:0]      r_phi;
    logic [27:0]      lhs;
    logic [SUM_W-1:0] sq;
    t_root            r_root, n_root;

    always_comb begin
        av = i_sum.gv[GRAD_W-1] ? ABS_W'(-i_sum.gv) : ABS_W'(i_sum.gv);
        ah = i_sum.gh[GRAD_W-1] ? ABS_W'(-i_sum.gh) : ABS_W'(i_sum.gh);
    end

    always_comb begin
        lhs = {2'b00, r_ah, 16'h0000};
        sq  = SUM_W'(r_sqv) + SUM_W'(r_sqh);
        n_root.vld  = r_vld;
        n_root.sat  = |sq[SUM_W-1:VAL_W];
        n_root.val  = sq[VAL_W-1:0];
        n_root.rem  = '0;
        n_root.root = '0;
        priority if (lhs < {3'b000, r_plo}) begin
            n_root.dir = DIR_HORIZ;
        end else if (lhs > r_phi) begin
            n_root.dir = DIR_VERT;
        end else if (r_same_sign) begin
            n_root.dir = DIR_PLUS;
        end else begin
            n_root.dir = DIR_MINUS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_root.vld <= 1'b0;
        end else if (i_en) begin
            r_vld       <= i_sum.vld;
            r_same_sign <= (i_sum.gv != '0) && (i_sum.gh != '0)
                           && (i_sum.gv[GRAD_W-1] == i_sum.gh[GRAD_W-1]);
            r_ah        <= ah;
            r_sqv       <= SQ_W'(av) * SQ_W'(av);
            r_sqh       <= SQ_W'(ah) * SQ_W'(ah);
            r_plo       <= 25'(TAN_LOW_Q16) * 25'(av);
            r_phi       <= 28'(TAN_HIGH_Q16) * 28'(av);
            r_root      <= n_root;
        end
    end

    assign o_root = r_root;

endmodule

// File: hw/rtl/sgm_sqrt.sv
// Pipelined integer square root, two result bits per stage, with saturation pass-through.
// Uses sgm_pkg.
module sgm_sqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  sgm_pkg::t_root i_root,
    output sgm_pkg::t_res  o_res
);
    import sgm_pkg::*;

    t_root r_stg [SQRT_STAGES];
    t_root n_stg [SQRT_STAGES];

    function automatic t_root sqrt_step(input t_root s);
        logic [REM_W:0]   rem_sh;
        logic [REM_W:0]   trial;
        t_root            t;
        rem_sh = {s.rem[REM_W-2:0], s.val[VAL_W-1 -: 2]};
        trial  = {1'b0, s.root, 2'b01};
        t      = s;
        t.val  = {s.val[VAL_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            t.rem  = REM_W'(rem_sh - trial);
            t.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            t.rem  = rem_sh[REM_W-1:0];
            t.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return t;
    endfunction

    always_comb begin
        for (int k = 0; k < SQRT_STAGES; k++) begin
            n_stg[k] = (k == 0) ? i_root : r_stg[(k == 0) ? 0 : k - 1];
            for (int j = 0; j < SQRT_STEPS; j++) begin
                n_stg[k] = sqrt_step(n_stg[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQRT_STAGES; k++) begin
                r_stg[k].vld <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < SQRT_STAGES; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    always_comb begin
        o_res.vld = r_stg[SQRT_STAGES-1].vld;
        o_res.mag = r_stg[SQRT_STAGES-1].sat ? MAG_SAT : r_stg[SQRT_STAGES-1].root;
        o_res.dir = r_stg[SQRT_STAGES-1].dir;
    end

endmodule

// File: hw/rtl/sgm_out.sv
// Output register with one pending word; serializes the two lanes and drives the
// pipeline enable. Uses sgm_pkg.
module sgm_out (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sgm_pkg::t_res             i_res_a,
    input  sgm_pkg::t_res             i_res_b,
    input  logic                      i_stall,
    output logic                      o_en,
    output logic                      o_valid,
    output logic [sgm_pkg::ROOT_W-1:0] o_magnitude,
    output logic [1:0]                o_direction,
    output logic                      o_row_end
);
    import sgm_pkg::*;

    logic              r_out_valid, r_pend_valid;
    logic [ROOT_W-1:0] r_mag;
    logic [1:0]        r_dir;
    logic              r_end;
    t_res              r_pend;
    logic              take, can_load;

    assign take     = r_out_valid && !i_stall;
    assign can_load = !r_pend_valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (r_pend_valid) begin
            if (take) begin
                r_mag        <= r_pend.mag;
                r_dir        <= r_pend.dir;
                r_end        <= 1'b1;
                r_pend_valid <= 1'b0;
            end
        end else if (can_load) begin
            if (i_res_a.vld) begin
                r_out_valid  <= 1'b1;
                r_mag        <= i_res_a.mag;
                r_dir        <= i_res_a.dir;
                r_end        <= 1'b0;
                r_pend       <= i_res_b;
                r_pend_valid <= i_res_b.vld;
            end else if (i_res_b.vld) begin
                r_out_valid <= 1'b1;
                r_mag       <= i_res_b.mag;
                r_dir       <= i_res_b.dir;
                r_end       <= 1'b1;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_en        = can_load;
    assign o_valid     = r_out_valid;
    assign o_magnitude = r_mag;
    assign o_direction = r_dir;
    assign o_row_end   = r_end;

endmodule

// File: hw/rtl/sobel_gradient_magnitude_direction.sv
// Sobel 3x3 gradient magnitude and direction over a column stream.
// Pipeline registers: column window, 2 gradient stages, 4 sqrt stages, output register.
// Throughput: one column word per cycle while i_stall is low; a row-final column after an
// interior one yields two words; the pipeline holds while the second word is pending.
// Reset (i_rst_n low, synchronous): column window, valid bits and skid buffer cleared.
// Uses sgm_pkg, sgm_window, sgm_grad, sgm_sqrt, sgm_out.
module sobel_gradient_magnitude_direction (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [sgm_pkg::PIX_W-1:0]  i_pixel_above,
    input  logic [sgm_pkg::PIX_W-1:0]  i_pixel_middle,
    input  logic [sgm_pkg::PIX_W-1:0]  i_pixel_below,
    input  logic                       i_row_first,
    input  logic                       i_row_final,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [sgm_pkg::ROOT_W-1:0] o_magnitude,
    output logic [1:0]                 o_direction,
    output logic                       o_row_end
);
    import sgm_pkg::*;

    logic                  r_skid_full;
    logic [2:0][PIX_W-1:0] r_skid_col;
    logic                  r_skid_first, r_skid_final;
    logic                  pipe_en;
    logic                  in_vld, in_first, in_final;
    logic [2:0][PIX_W-1:0] in_col;
    t_sum                  sum_a, sum_b;
    t_root                 root_a, root_b;
    t_res                  res_a, res_b;

    assign o_stall = r_skid_full;

    always_comb begin
        if (r_skid_full) begin
            in_vld   = 1'b1;
            in_col   = r_skid_col;
            in_first = r_skid_first;
            in_final = r_skid_final;
        end else begin
            in_vld   = i_valid;
            in_col   = {i_pixel_below, i_pixel_middle, i_pixel_above};
            in_first = i_row_first;
            in_final = i_row_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_full <= 1'b0;
        end else if (r_skid_full) begin
            if (pipe_en) begin
                r_skid_full <= 1'b0;
            end
        end else if (i_valid && !pipe_en) begin
            r_skid_full  <= 1'b1;
            r_skid_col   <= {i_pixel_below, i_pixel_middle, i_pixel_above};
            r_skid_first <= i_row_first;
            r_skid_final <= i_row_final;
        end
    end

    sgm_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (in_vld),
        .i_col   (in_col),
        .i_first (in_first),
        .i_final (in_final),
        .o_sum_a (sum_a),
        .o_sum_b (sum_b)
    );

    sgm_grad u_grad_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_sum   (sum_a),
        .o_root  (root_a)
    );

    sgm_grad u_grad_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_sum   (sum_b),
        .o_root  (root_b)
    );

    sgm_sqrt u_sqrt_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_root  (root_a),
        .o_res   (res_a)
    );

    sgm_sqrt u_sqrt_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_root  (root_b),
        .o_res   (res_b)
    );

    sgm_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_a     (res_a),
        .i_res_b     (res_b),
        .i_stall     (i_stall),
        .o_en        (pipe_en),
        .o_valid     (o_valid),
        .o_magnitude (o_magnitude),
        .o_direction (o_direction),
        .o_row_end   (o_row_end)
    );

    // pipeline only freezes while a result word waits at the output
    a_freeze_needs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pipe_en |-> o_valid)
        else $error("pipeline frozen with no output word");

    // a word taken while the pipeline is frozen lands in the skid stage
    a_skid_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !pipe_en) |=> o_stall)
        else $error("accepted word not held in skid stage");

    // skid stage holds until the pipeline moves
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stall && !pipe_en) |=> o_stall)
        else $error("skid word dropped while pipeline frozen");

endmodule

// File: tb/sobel_gradient_magnitude_direction_test.sv
// Self-checking testbench for sobel_gradient_magnitude_direction: directed rows, then random rows.
// Predicts magnitude, direction sector and row end per result word; depends on sgm_pkg and the RTL.
`timescale 1ns / 1ps

module sobel_gradient_magnitude_direction_test;
    import sgm_pkg::*;

    typedef logic [2:0][PIX_W-1:0] t_column;   // [0] above, [1] middle, [2] below

    typedef struct {
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] middle;
        logic [PIX_W-1:0] below;
        logic             row_first;
        logic             row_final;
    } t_column_word;

    typedef struct {
        logic [ROOT_W-1:0] magnitude;
        logic [1:0]        direction;
        logic              row_end;
    } t_grad_result;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [PIX_W-1:0]  i_pixel_above = '0;
    logic [PIX_W-1:0]  i_pixel_middle = '0;
    logic [PIX_W-1:0]  i_pixel_below = '0;
    logic              i_row_first = 1'b0;
    logic              i_row_final = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [ROOT_W-1:0] o_magnitude;
    logic [1:0]        o_direction;
    logic              o_row_end;

    sobel_gradient_magnitude_direction i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_above  (i_pixel_above),
        .i_pixel_middle (i_pixel_middle),
        .i_pixel_below  (i_pixel_below),
        .i_row_first    (i_row_first),
        .i_row_final    (i_row_final),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_magnitude    (o_magnitude),
        .o_direction    (o_direction),
        .o_row_end      (o_row_end)
    );

    t_column_word pending_columns[$];
    t_grad_result expected_grads[$];

    t_column window_center = '0;
    t_column window_left = '0;
    int      window_fill = 0;

    int  errors = 0;
    int  words_sent = 0;
    int  rows_sent = 0;
    int  results_checked = 0;
    int  row_ends_seen = 0;
    int  sector_hits[4] = '{0, 0, 0, 0};
    logic word_taken = 1'b0;

    int  send_gap = 0;
    int  send_phase_left = 0;
    bit  send_calm = 1'b0;
    int  stall_left = 0;
    int  recv_phase_left = 0;
    bit  recv_calm = 1'b0;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_grad_result sobel_eval(t_column lc, t_column cc, t_column rc, logic last);
        t_grad_result res;
        int     gv;
        int     gh;
        int     av;
        int     ah;
        int     sq;
        int     root;
        int     trial;
        longint lhs;
        gv = (int'(lc[2]) + 2 * int'(cc[2]) + int'(rc[2]))
           - (int'(lc[0]) + 2 * int'(cc[0]) + int'(rc[0]));
        gh = (int'(rc[0]) + 2 * int'(rc[1]) + int'(rc[2]))
           - (int'(lc[0]) + 2 * int'(lc[1]) + int'(lc[2]));
        av = (gv < 0) ? -gv : gv;
        ah = (gh < 0) ? -gh : gh;
        sq = av * av + ah * ah;
        root = 0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= sq) root = trial;
        end
        res.magnitude = (sq >= 65536) ? MAG_SAT : root[ROOT_W-1:0];
        lhs = longint'(ah) << 16;
        if (lhs < longint'(TAN_LOW_Q16) * av) res.direction = DIR_HORIZ;
        else if (lhs > longint'(TAN_HIGH_Q16) * av) res.direction = DIR_VERT;
        else if (gv != 0 && gh != 0 && ((gv > 0) == (gh > 0))) res.direction = DIR_PLUS;
        else res.direction = DIR_MINUS;
        res.row_end = last;
        return res;
    endfunction

    task automatic predict_column(t_column_word w);
        t_column col;
        col = {w.below, w.middle, w.above};
        if (w.row_first || window_fill == 0) begin
            window_left = '0;
            window_center = col;
            window_fill = 1;
        end else begin
            expected_grads.push_back(sobel_eval(window_left, window_center, col, 1'b0));
            window_left = window_center;
            window_center = col;
            window_fill = 2;
        end
        if (w.row_final) begin
            expected_grads.push_back(sobel_eval(window_left, window_center, '0, 1'b1));
            window_left = '0;
            window_center = '0;
            window_fill = 0;
        end
    endtask

    task automatic queue_column(int a, int m, int b, bit first, bit last);
        t_column_word w;
        w.above = a[PIX_W-1:0];
        w.middle = m[PIX_W-1:0];
        w.below = b[PIX_W-1:0];
        w.row_first = first;
        w.row_final = last;
        pending_columns.push_back(w);
        words_sent++;
        if (last) rows_sent++;
    endtask

    function automatic int pick_pixel(int style, int base, int pos);
        int v;
        case (style)
            0: v = $urandom_range(0, 255);
            1: v = $urandom_range(0, 1) ? 255 : 0;
            2: v = base + $urandom_range(0, 8) - 4;
            default: v = base + pos * 16;
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v;
    endfunction

    task automatic queue_row(int len, bit drop_first, bit drop_final);
        int style;
        int base;
        style = $urandom_range(0, 3);
        base = $urandom_range(0, 255);
        for (int i = 0; i < len; i++) begin
            queue_column(pick_pixel(style, base, i), pick_pixel(style, base, i + 1),
                         pick_pixel(style, base, i + 2),
                         (i == 0) && !drop_first, (i == len - 1) && !drop_final);
        end
    endtask

    // sender: holds the word until taken, then optional gap
    always @(negedge i_clk) begin
        if (send_phase_left == 0) begin
            send_calm = ($urandom_range(0, 3) == 0);
            send_phase_left = $urandom_range(40, 150);
        end else begin
            send_phase_left--;
        end
        if (i_rst_n && (!i_valid || word_taken)) begin
            if (send_gap > 0 || pending_columns.size() == 0) begin
                i_valid <= 1'b0;
                if (send_gap > 0) send_gap--;
            end else begin
                t_column_word w;
                w = pending_columns.pop_front();
                i_pixel_above  <= w.above;
                i_pixel_middle <= w.middle;
                i_pixel_below  <= w.below;
                i_row_first    <= w.row_first;
                i_row_final    <= w.row_final;
                i_valid        <= 1'b1;
                send_gap = send_calm ? 0 : pick_gap();
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (recv_phase_left == 0) begin
            recv_calm = ($urandom_range(0, 3) == 0);
            recv_phase_left = $urandom_range(40, 150);
        end else begin
            recv_phase_left--;
        end
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
            if (!recv_calm) stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_grad_result exp_res;
        word_taken <= i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            t_column_word w;
            w.above = i_pixel_above;
            w.middle = i_pixel_middle;
            w.below = i_pixel_below;
            w.row_first = i_row_first;
            w.row_final = i_row_final;
            predict_column(w);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_grads.size() == 0) begin
                $error("result word with nothing pending: magnitude %0d direction %0d row_end %0d",
                       o_magnitude, o_direction, o_row_end);
                errors++;
            end else begin
                exp_res = expected_grads.pop_front();
                results_checked++;
                sector_hits[exp_res.direction]++;
                if (exp_res.row_end) row_ends_seen++;
                if (o_magnitude !== exp_res.magnitude) begin
                    $error("magnitude: expected %0d, actual %0d", exp_res.magnitude, o_magnitude);
                    errors++;
                end
                if (o_direction !== exp_res.direction) begin
                    $error("direction: expected %0d, actual %0d", exp_res.direction, o_direction);
                    errors++;
                end
                if (o_row_end !== exp_res.row_end) begin
                    $error("row_end: expected %0d, actual %0d", exp_res.row_end, o_row_end);
                    errors++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", expected_grads.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin
        // single-column rows: zero gradient, saturated vertical sums
        queue_column(0, 0, 0, 1, 1);
        queue_column(0, 0, 255, 1, 1);
        queue_column(255, 0, 0, 1, 1);
        // flat bars: pure horizontal sum, saturated
        queue_column(0, 0, 0, 1, 0);
        queue_column(255, 255, 255, 0, 0);
        queue_column(255, 255, 255, 0, 0);
        queue_column(0, 0, 0, 0, 1);
        // diagonal edges
        queue_column(0, 0, 0, 1, 0);
        queue_column(0, 0, 255, 0, 0);
        queue_column(0, 255, 255, 0, 1);
        queue_column(0, 0, 0, 1, 0);
        queue_column(255, 0, 0, 0, 0);
        queue_column(255, 255, 0, 0, 1);
        queue_column(1, 2, 3, 1, 0);
        queue_column(4, 5, 6, 0, 0);
        queue_column(7, 8, 9, 0, 1);
        // no row start after a flush
        queue_column(10, 20, 30, 0, 0);
        queue_column(40, 50, 60, 0, 1);
        // row start in the middle of a row
        queue_column(1, 1, 1, 1, 0);
        queue_column(2, 2, 2, 0, 0);
        queue_column(3, 3, 3, 1, 0);
        queue_column(4, 4, 4, 0, 1);
        queue_column(100, 0, 200, 1, 0);
        queue_column(200, 0, 100, 0, 1);

        while (words_sent < 850) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 80) begin
                queue_row($urandom_range(0, 9) == 0 ? $urandom_range(9, 40) : $urandom_range(1, 8),
                          1'b0, 1'b0);
            end else if (r < 90) begin
                queue_row($urandom_range(1, 8), $urandom_range(0, 1) == 1,
                          $urandom_range(0, 1) == 1);
            end else begin
                queue_column($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255),
                             $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0);
            end
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_columns.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_grads.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (expected_grads.size() > 0) begin
            $error("%0d expected results never arrived", expected_grads.size());
            errors++;
        end
        $display("Sent %0d column words (%0d flushed rows); checked %0d results, %0d row ends.",
                 words_sent, rows_sent, results_checked, row_ends_seen);
        $display("Sectors: horizontal %0d, vertical %0d, plus 45 %0d, minus 45 %0d.",
                 sector_hits[DIR_HORIZ], sector_hits[DIR_VERT],
                 sector_hits[DIR_PLUS], sector_hits[DIR_MINUS]);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sobel_gradient_magnitude_direction.f
hw/rtl/sgm_pkg.sv
hw/rtl/sgm_window.sv
hw/rtl/sgm_grad.sv
hw/rtl/sgm_sqrt.sv
hw/rtl/sgm_out.sv
hw/rtl/sobel_gradient_magnitude_direction.sv
tb/sobel_gradient_magnitude_direction_test.sv
